>>> hdl/rgr_pkg.sv
package rgr_pkg;

  // Default size of the graph; the matrix never grows beyond the 6-bit node fields.
  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_FIELD_MAX = 64;

  // Command codes.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_REJECTED    = 3'd1;
  localparam logic [2:0] ST_CLEARED     = 3'd2;
  localparam logic [2:0] ST_ALL_REACHED = 3'd3;
  localparam logic [2:0] ST_UNREACHABLE = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [1:0] command;
    logic [5:0] node_a;
    logic [5:0] node_b;
  } rgr_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] unreachable_node;
  } rgr_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;     // capture the endpoints of an accepted add
    logic       rd_b;      // read row node_b (row node_a otherwise)
    logic       rd_ptr;    // read the row under the scan pointer and expand it
    logic       wr_a;      // write row node_a with bit node_b set
    logic       wr_b;      // write row node_b with bit node_a set
    logic       clr;       // empty the whole matrix
    logic       chk_init;  // start a check with only node zero reached
    logic       ptr_clr;   // scan pointer back to node zero
    logic       ptr_inc;   // scan pointer to the next defined node
    logic       res_we;    // present a result beat
    logic [2:0] res_code;  // status of that beat
  } rgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic add_ok;        // both endpoints of the offered add are defined nodes
    logic n_zero;        // no node is defined
    logic pending_zero;  // every reached node has had its row expanded
    logic scan_hit;      // node under the pointer is defined and not reached
    logic scan_last;     // pointer stands on the last defined node
  } rgr_stat_t;

endpackage

>>> hdl/rgr_ctrl.sv
module rgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          command,
  input  rgr_pkg::rgr_stat_t  stat,
  output rgr_pkg::rgr_cmd_t   cmd,
  output logic                busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_A  = 3'd1;
  localparam logic [2:0] S_WR_A  = 3'd2;
  localparam logic [2:0] S_RD_B  = 3'd3;
  localparam logic [2:0] S_WR_B  = 3'd4;
  localparam logic [2:0] S_EXP   = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            rgr_pkg::CMD_ADD: begin
              if (stat.add_ok) begin
                cmd.latch  = 1'b1;
                state_next = S_RD_A;
              end else begin
                cmd.res_we   = 1'b1;
                cmd.res_code = rgr_pkg::ST_REJECTED;
              end
            end
            rgr_pkg::CMD_CHECK: begin
              if (stat.n_zero) begin
                cmd.res_we   = 1'b1;
                cmd.res_code = rgr_pkg::ST_ALL_REACHED;
              end else begin
                cmd.chk_init = 1'b1;
                cmd.ptr_clr  = 1'b1;
                state_next   = S_EXP;
              end
            end
            rgr_pkg::CMD_CLEAR: begin
              cmd.clr      = 1'b1;
              cmd.res_we   = 1'b1;
              cmd.res_code = rgr_pkg::ST_CLEARED;
            end
            default: begin
              cmd.res_we   = 1'b1;
              cmd.res_code = rgr_pkg::ST_REJECTED;
            end
          endcase
        end
      end
      // The read port addresses row node_a when nothing else is asked for.
      S_RD_A: begin
        state_next = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b     = 1'b1;
        cmd.res_we   = 1'b1;
        cmd.res_code = rgr_pkg::ST_STORED;
        state_next   = S_IDLE;
      end
      // Sweep the rows round and round until no reached node is left unexpanded.
      S_EXP: begin
        if (stat.pending_zero) begin
          cmd.ptr_clr = 1'b1;
          state_next  = S_SCAN;
        end else begin
          cmd.rd_ptr  = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      // Walk up from node zero to the first defined node that was not reached.
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = rgr_pkg::ST_UNREACHABLE;
          state_next   = S_IDLE;
        end else if (stat.scan_last) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = rgr_pkg::ST_ALL_REACHED;
          state_next   = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rgr_datapath.sv
module rgr_datapath #(
  parameter int MAX_NODES = rgr_pkg::MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  input  rgr_pkg::rgr_item_t   item,
  input  rgr_pkg::rgr_cmd_t    cmd,
  output rgr_pkg::rgr_stat_t   stat,
  output rgr_pkg::rgr_result_t result,
  output logic                 done
);

  localparam int N  = (MAX_NODES < rgr_pkg::NODE_FIELD_MAX) ? MAX_NODES
                                                            : rgr_pkg::NODE_FIELD_MAX;
  localparam int IW = $clog2(N);

  logic [6:0]    node_count;
  logic [6:0]    n_eff;
  logic [N-1:0]  valid;
  logic [5:0]    a_q;
  logic [5:0]    b_q;
  logic [N-1:0]  rows [N];
  logic [N-1:0]  row_valid;
  logic [N-1:0]  rd_data;
  logic          rd_hit;
  logic          exp_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_bit;
  logic          wr_en;
  logic [N-1:0]  row_eff;
  logic [N-1:0]  wr_data;
  logic [IW-1:0] ptr;
  logic [N-1:0]  visited;
  logic [N-1:0]  expanded;
  logic [N-1:0]  pending;

  // Node count register; counts above the matrix size saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  assign n_eff = (node_count > 7'(N)) ? 7'(N) : node_count;

  // One bit per defined node.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = (7'(i) < n_eff);
    end
  end

  // Endpoints of an add.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      a_q <= item.node_a;
      b_q <= item.node_b;
    end
  end

  // Matrix port selection.
  assign rd_addr = cmd.rd_ptr ? ptr : (cmd.rd_b ? b_q[IW-1:0] : a_q[IW-1:0]);
  assign wr_addr = cmd.wr_b ? b_q[IW-1:0] : a_q[IW-1:0];
  assign wr_bit  = cmd.wr_b ? a_q[IW-1:0] : b_q[IW-1:0];
  assign wr_en   = cmd.wr_a | cmd.wr_b;
  assign row_eff = rd_hit ? rd_data : '0;
  assign wr_data = row_eff | ({{(N-1){1'b0}}, 1'b1} << wr_bit);

  // Adjacency matrix, one row per node, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= wr_data;
    end
    rd_data <= rows[rd_addr];
    idx_q   <= rd_addr;
  end

  // Row valid bits; a row never written since the last clear reads as empty.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_hit <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_q <= 1'b0;
    end else begin
      exp_q <= cmd.rd_ptr;
    end
  end

  // Reached set and expanded set of the running check.
  assign pending = visited & ~expanded;

  always_ff @(posedge clk) begin
    if (cmd.chk_init) begin
      visited  <= {{(N-1){1'b0}}, 1'b1};
      expanded <= '0;
    end else if (exp_q && pending[idx_q]) begin
      visited         <= visited | (row_eff & valid);
      expanded[idx_q] <= 1'b1;
    end
  end

  // Scan pointer, wrapping after the last defined node.
  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= stat.scan_last ? '0 : ptr + IW'(1);
    end
  end

  // Status to the controller.
  always_comb begin
    stat.add_ok       = (7'(item.node_a) < n_eff) && (7'(item.node_b) < n_eff);
    stat.n_zero       = (n_eff == 7'd0);
    stat.pending_zero = (pending == '0);
    stat.scan_hit     = valid[ptr] & ~visited[ptr];
    stat.scan_last    = (7'(ptr) == n_eff - 7'd1);
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      result.status           <= cmd.res_code;
      result.unreachable_node <= (cmd.res_code == rgr_pkg::ST_UNREACHABLE) ? 6'(ptr) : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_we;
    end
  end

endmodule

>>> hdl/room_graph_reachability.sv
// Channel   Ports                     Beat taken when
// --------  ------------------------  ---------------------------
// config    cfg_we, cfg_data          cfg_we high at a clock edge
// command   start, busy, item         start high and busy low
// result    done, result              done high (one cycle only)
//
// An add steps through the states RD_A, WR_A, RD_B and WR_B before its result is
// registered; clear and rejected commands give their result in the next cycle
// without raising busy. A check sweeps the adjacency memory one row a cycle, round
// and round, until every reached node has been expanded, then scans for the lowest
// missed node, reading rows through the single read port of the row memory. Reset
// (rst, synchronous) empties the graph and clears the node count. Results cannot
// be held off by the receiver.
module room_graph_reachability #(
  parameter int MAX_NODES = rgr_pkg::MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  rgr_pkg::rgr_item_t   item,
  output logic                 done,
  output rgr_pkg::rgr_result_t result
);

  rgr_pkg::rgr_cmd_t  cmd;
  rgr_pkg::rgr_stat_t stat;

  rgr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rgr_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result),
    .done     (done)
  );

  // Every accepted command either answers at once or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command produced neither a result nor busy");

  // Leaving a busy phase always delivers its result beat.
  assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy phase ended without a result");

  // The node index only carries meaning with the unreachable status.
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != rgr_pkg::ST_UNREACHABLE)) |-> (result.unreachable_node == 6'd0))
    else $error("unreachable_node set on a result without unreachable status");

endmodule

>>> tb/sv/tb_room_graph_reachability.sv
module tb_room_graph_reachability;
  timeunit 1ns;
  timeprecision 1ps;

  // Command value that the block treats as unknown.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles to let pass after the last result before touching the register.
  localparam int DRAIN_CYCLES = 8;
  // A full check over 64 nodes passes no beat in either direction while it runs.
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_REPORTS = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [6:0]           cfg_data;
  logic                 start;
  logic                 busy;
  rgr_pkg::rgr_item_t   item;
  logic                 done;
  rgr_pkg::rgr_result_t result;

  room_graph_reachability u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result)
  );

  // Shadow copy of the graph and the node count register.
  logic [63:0] model_rows [64];
  logic [6:0]  model_count;

  // Results predicted for accepted commands, oldest first.
  rgr_pkg::rgr_result_t pending_results [$];

  bit burst_mode;
  int items_sent       = 0;
  int results_seen     = 0;
  int settings_written = 0;
  int checks_full      = 0;
  int checks_missed    = 0;
  int error_count      = 0;
  int stall_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    error_count++;
  endtask

  // Number of nodes the block actually uses: the count saturates at 64.
  function automatic int defined_nodes();
    return (model_count > 7'd64) ? 64 : int'(model_count);
  endfunction

  // Work out the result of one command and update the shadow graph.
  function automatic rgr_pkg::rgr_result_t predict_result(input rgr_pkg::rgr_item_t beat);
    rgr_pkg::rgr_result_t res;
    int          n;
    logic [63:0] valid_nodes;
    logic [63:0] reached;
    logic [63:0] frontier;
    logic [63:0] grown;
    logic [63:0] missed;
    n = defined_nodes();
    res.status = rgr_pkg::ST_REJECTED;
    res.unreachable_node = '0;
    case (beat.command)
      rgr_pkg::CMD_ADD: begin
        if (beat.node_a < n && beat.node_b < n) begin
          model_rows[beat.node_a][beat.node_b] = 1'b1;
          model_rows[beat.node_b][beat.node_a] = 1'b1;
          res.status = rgr_pkg::ST_STORED;
        end
      end
      rgr_pkg::CMD_CLEAR: begin
        for (int i = 0; i < 64; i++) model_rows[i] = '0;
        res.status = rgr_pkg::ST_CLEARED;
      end
      rgr_pkg::CMD_CHECK: begin
        res.status = rgr_pkg::ST_ALL_REACHED;
        if (n > 0) begin
          valid_nodes = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
          reached = 64'd1;
          frontier = 64'd1;
          // Expand the frontier until no new defined node turns up.
          while (frontier != '0) begin
            grown = '0;
            for (int i = 0; i < 64; i++) begin
              if (frontier[i]) grown |= model_rows[i];
            end
            grown &= valid_nodes & ~reached;
            reached |= grown;
            frontier = grown;
          end
          missed = valid_nodes & ~reached;
          if (missed != '0) begin
            res.status = rgr_pkg::ST_UNREACHABLE;
            for (int i = 63; i >= 0; i--) begin
              if (missed[i]) res.unreachable_node = 6'(i);
            end
          end
        end
        if (res.status == rgr_pkg::ST_UNREACHABLE) checks_missed++;
        else checks_full++;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Gap before a command beat: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one command beat and record its expected result once it is taken.
  task automatic send_item(input logic [1:0] cmd, input logic [5:0] a, input logic [5:0] b);
    rgr_pkg::rgr_item_t   beat;
    rgr_pkg::rgr_result_t expected;
    int                   gap;
    beat.command = cmd;
    beat.node_a = a;
    beat.node_b = b;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected = predict_result(beat);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  // Stop offering commands and wait until every result has come back.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block has nothing in flight.
  task automatic cfg_write(input logic [6:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_count = value;
    settings_written++;
  endtask

  function automatic rgr_pkg::rgr_item_t random_item(input int n);
    rgr_pkg::rgr_item_t beat;
    int                 roll;
    roll = $urandom_range(0, 99);
    beat.node_a = 6'($urandom_range(0, 63));
    beat.node_b = 6'($urandom_range(0, 63));
    if (roll < 50) begin
      beat.command = rgr_pkg::CMD_ADD;
      if (n > 0) begin
        beat.node_a = 6'($urandom_range(0, n - 1));
        beat.node_b = 6'($urandom_range(0, n - 1));
      end
    end else if (roll < 62) begin
      beat.command = rgr_pkg::CMD_ADD;
    end else if (roll < 76) begin
      beat.command = rgr_pkg::CMD_CHECK;
    end else if (roll < 86) begin
      beat.command = rgr_pkg::CMD_CLEAR;
    end else begin
      beat.command = CMD_UNUSED;
    end
    return beat;
  endfunction

  // Clear, build a spanning tree over relabeled nodes (sometimes with one
  // edge cut), add a few extra edges, then check reachability.
  task automatic send_tree_graph(input int n);
    int                 label [64];
    int                 edge_a [128];
    int                 edge_b [128];
    int                 edges;
    int                 pick;
    int                 tmp;
    rgr_pkg::rgr_item_t noise;
    edges = 0;
    for (int i = 0; i < 64; i++) label[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = label[i];
      label[i] = label[pick];
      label[pick] = tmp;
    end
    for (int i = 1; i < n; i++) begin
      edge_a[edges] = label[i];
      edge_b[edges] = label[$urandom_range(0, i - 1)];
      edges++;
    end
    // Cutting one tree edge leaves a subtree unreachable unless an extra edge fixes it.
    if (n > 1 && $urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, edges - 1);
      edge_a[pick] = edge_a[edges - 1];
      edge_b[pick] = edge_b[edges - 1];
      edges--;
    end
    if (n > 0) begin
      repeat ($urandom_range(0, 3)) begin
        edge_a[edges] = $urandom_range(0, n - 1);
        edge_b[edges] = $urandom_range(0, n - 1);
        edges++;
      end
    end
    for (int i = edges - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = edge_a[i];
      edge_a[i] = edge_a[pick];
      edge_a[pick] = tmp;
      tmp = edge_b[i];
      edge_b[i] = edge_b[pick];
      edge_b[pick] = tmp;
    end
    send_item(rgr_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        noise = random_item(n);
        if (noise.command == rgr_pkg::CMD_ADD || noise.command == CMD_UNUSED) begin
          send_item(noise.command, noise.node_a, noise.node_b);
        end
      end
      if ($urandom_range(0, 1) == 0) send_item(rgr_pkg::CMD_ADD, 6'(edge_a[i]), 6'(edge_b[i]));
      else send_item(rgr_pkg::CMD_ADD, 6'(edge_b[i]), 6'(edge_a[i]));
    end
    // Now and then let the block drain completely before the check.
    if ($urandom_range(0, 3) == 0) wait_idle();
    send_item(rgr_pkg::CMD_CHECK, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  task automatic send_noise(input int n);
    rgr_pkg::rgr_item_t beat;
    repeat ($urandom_range(4, 16)) begin
      beat = random_item(n);
      send_item(beat.command, beat.node_a, beat.node_b);
    end
    send_item(rgr_pkg::CMD_CHECK, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  // With no nodes defined every add is rejected and the empty graph is reachable; then one node is defined.
  task automatic test_empty_graph();
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
    send_item(rgr_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(CMD_UNUSED, 6'd63, 6'd63);
    send_item(rgr_pkg::CMD_CLEAR, 6'd0, 6'd0);
    cfg_write(7'd1);
    send_item(rgr_pkg::CMD_CHECK, 6'd63, 6'd63);
    send_item(rgr_pkg::CMD_ADD, 6'd0, 6'd0);
  endtask

  // Self loops, duplicates, endpoints out of range and the unused command.
  task automatic test_edge_rules();
    cfg_write(7'd4);
    send_item(rgr_pkg::CMD_ADD, 6'd0, 6'd1);
    send_item(rgr_pkg::CMD_ADD, 6'd1, 6'd1);
    send_item(rgr_pkg::CMD_ADD, 6'd1, 6'd0);
    send_item(rgr_pkg::CMD_ADD, 6'd2, 6'd4);
    send_item(rgr_pkg::CMD_ADD, 6'd63, 6'd0);
    send_item(CMD_UNUSED, 6'd1, 6'd2);
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
    send_item(rgr_pkg::CMD_ADD, 6'd1, 6'd2);
    send_item(rgr_pkg::CMD_ADD, 6'd3, 6'd2);
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
  endtask

  // Lowering the count hides stored edges; a count above 64 saturates.
  task automatic test_node_count_changes();
    cfg_write(7'd2);
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
    cfg_write(7'd127);
    send_item(rgr_pkg::CMD_ADD, 6'd63, 6'd3);
    send_item(rgr_pkg::CMD_ADD, 6'd0, 6'd63);
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
    cfg_write(7'd64);
    send_item(rgr_pkg::CMD_CLEAR, 6'd63, 6'd63);
    send_item(rgr_pkg::CMD_CHECK, 6'd0, 6'd0);
    send_item(rgr_pkg::CMD_ADD, 6'd63, 6'd62);
  endtask

  // Random phases, each with its own node count and idling style.
  task automatic test_random_graphs();
    int stop_at;
    int roll;
    int setting;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) setting = 0;
      else if (roll < 45) setting = $urandom_range(1, 8);
      else if (roll < 72) setting = $urandom_range(9, 24);
      else if (roll < 84) setting = $urandom_range(25, 63);
      else if (roll < 92) setting = 64;
      else setting = $urandom_range(65, 127);
      cfg_write(7'(setting));
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) != 0) send_tree_graph(defined_nodes());
        else send_noise(defined_nodes());
      end
    end
    burst_mode = 1'b0;
  endtask

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    rgr_pkg::rgr_result_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat status %0d with nothing expected",
                                  result.status));
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        end
        if (result.unreachable_node !== want.unreachable_node) begin
          report_mismatch($sformatf("unreachable_node %0d, expected %0d",
                                    result.unreachable_node, want.unreachable_node));
        end
      end
    end
  end

  // End the run if no beat moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    model_count = '0;
    burst_mode = 1'b0;
    for (int i = 0; i < 64; i++) model_rows[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_graph();
    test_edge_rules();
    test_node_count_changes();
    test_random_graphs();

    wait_idle();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d commands and %0d result beats over %0d node count settings",
             items_sent, results_seen, settings_written);
    $display("reachability checks: %0d fully connected, %0d with a missed node",
             checks_full, checks_missed);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
